### hw/rtl/timer_divider_pair_search_assert.svh
// Assertion macros for the timer divider pair search block.
// Used by the divider and the top level; no other dependencies.
`ifndef TIMER_DIVIDER_PAIR_SEARCH_ASSERT_SVH
`define TIMER_DIVIDER_PAIR_SEARCH_ASSERT_SVH
`define TDPS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define TDPS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### hw/rtl/tdps_pkg.sv
// Package for the timer divider pair search: widths, constants, divider request and response structs.
// No dependencies.
package tdps_pkg;
    localparam int unsigned W_DATA = 32;
    localparam int unsigned W_CNT  = 16;
    localparam int unsigned W_DIV  = 48;
    localparam int unsigned W_STEP = $clog2(W_DIV + 1);
    localparam logic [W_CNT-1:0]  COUNT_MAX   = 16'hFFFF;
    localparam logic [W_DATA-1:0] CLOCK_RESET = 32'd170000000;
    localparam logic [W_STEP-1:0] DIV_STEPS   = W_STEP'(W_DIV);

    typedef struct packed {
        logic              start;
        logic [W_DIV-1:0]  dividend;
        logic [W_DIV-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [W_DIV-1:0]  quotient;
    } t_div_rsp;
endpackage

### hw/rtl/tdps_if.sv
// Valid/ready channel interfaces for the timer divider pair search.
// Depends on tdps_pkg.
interface tdps_in_if;
    logic                      valid;
    logic                      ready;
    logic [tdps_pkg::W_DATA-1:0] req_hz;
    modport source (output valid, output req_hz, input ready);
    modport sink   (input valid, input req_hz, output ready);
endinterface

interface tdps_out_if;
    logic                      valid;
    logic                      ready;
    logic                      applied;
    logic [tdps_pkg::W_CNT-1:0]  prescaler;
    logic [tdps_pkg::W_CNT-1:0]  reload;
    logic [tdps_pkg::W_DATA-1:0] freq_error;
    modport source (output valid, output applied, output prescaler, output reload,
                    output freq_error, input ready);
    modport sink   (input valid, input applied, input prescaler, input reload,
                    input freq_error, output ready);
endinterface

### hw/rtl/timer_divider_pair_search.sv
// Timer divider pair search top level: config register and search sequencer.
// Each prescaler evaluated takes two divisions on the one shared divider, each skipped
// one takes one, up to 65536 prescalers; a zero target or clock skips the search.
// Throughput: one transaction at a time; not ready until the result is taken.
// Reset: synchronous active low; clock register returns to 170000000.
// Depends on tdps_pkg, tdps_if, tdps_sequencer and the assertion macro header.
`include "timer_divider_pair_search_assert.svh"
module timer_divider_pair_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tdps_pkg::W_DATA-1:0] i_cfg_wdata,
    tdps_in_if.sink                     in_ch,
    tdps_out_if.source                  out_ch
);
    import tdps_pkg::*;

    logic [W_DATA-1:0] r_clock_hz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_RESET;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_wdata;
        end
    end

    tdps_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clock_hz (r_clock_hz),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    `TDPS_ASSERT_IMP(a_excl, i_clk, i_rst_n, out_ch.valid, !in_ch.ready)
    `TDPS_ASSERT_NXT(a_take, i_clk, i_rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
    `TDPS_ASSERT_NXT(a_zero, i_clk, i_rst_n,
        in_ch.valid && in_ch.ready && in_ch.req_hz == '0,
        out_ch.valid && !out_ch.applied)
endmodule

### hw/rtl/tdps_divider.sv
// Shared restoring divider, one quotient bit a cycle.
// Depends on tdps_pkg and the assertion macro header.
`include "timer_divider_pair_search_assert.svh"
module tdps_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdps_pkg::t_div_req i_req,
    output tdps_pkg::t_div_rsp o_rsp
);
    import tdps_pkg::*;

    logic [W_DIV-1:0]  r_quo, n_quo;
    logic [W_DIV-1:0]  r_rem, n_rem;
    logic [W_DIV-1:0]  r_den;
    logic [W_STEP-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [W_DIV:0]    trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[W_DIV-1]} - {1'b0, r_den};
        if (r_busy) begin
            if (!trial[W_DIV]) begin
                n_rem = trial[W_DIV-1:0];
                n_quo = {r_quo[W_DIV-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[W_DIV-2:0], r_quo[W_DIV-1]};
                n_quo = {r_quo[W_DIV-2:0], 1'b0};
            end
            n_cnt = r_cnt - W_STEP'(1);
            if (r_cnt == W_STEP'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_STEPS;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `TDPS_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy)
    `TDPS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `TDPS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, r_busy, r_cnt != '0)
endmodule

### hw/rtl/tdps_sequencer.sv
// Search sequencer: walks prescalers, issues divisions, keeps the best pair.
// Depends on tdps_pkg, tdps_if and tdps_divider.
module tdps_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tdps_pkg::W_DATA-1:0] i_clock_hz,
    tdps_in_if.sink                     in_ch,
    tdps_out_if.source                  out_ch
);
    import tdps_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_DIV1  = 8'b0000_0100,
        S_ARR   = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIV2  = 8'b0010_0000,
        S_EVAL  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [W_DATA-1:0]    r_clk, r_tgt;
    logic [W_CNT:0]       r_psc;
    logic [W_DIV-1:0]     r_den, r_ideal;
    logic [W_CNT:0]       r_arr;
    logic [W_CNT-1:0]     r_win_psc, r_win_arr;
    logic [W_DATA:0]      r_best_err;
    logic                 r_have, r_applied;
    t_div_req             div_req;
    t_div_rsp             div_rsp;
    logic [W_DATA:0]      actual, err;
    logic [W_CNT:0]       arr_inc;
    logic [2*W_CNT+1:0]   prod_full;
    logic [W_DIV-1:0]     prod;
    logic                 win;

    tdps_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign arr_inc   = r_arr + (W_CNT+1)'(1);
    assign prod_full = {{(W_CNT+1){1'b0}}, r_psc} * {{(W_CNT+1){1'b0}}, arr_inc};
    assign prod      = W_DIV'(prod_full);
    assign actual = (W_DATA+1)'(div_rsp.quotient);
    assign err    = (actual > {1'b0, r_tgt}) ? actual - {1'b0, r_tgt}
                                            : {1'b0, r_tgt} - actual;
    assign win    = !r_have || (err < r_best_err) ||
                    ((err <= r_best_err + (W_DATA+1)'(1)) &&
                     (r_arr[W_CNT-1:0] > r_win_arr));

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        if (r_state == S_CHECK && r_den <= W_DIV'(r_clk) &&
            r_psc <= {1'b0, COUNT_MAX} + (W_CNT+1)'(1)) begin
            div_req.start    = 1'b1;
            div_req.dividend = W_DIV'(r_clk) + (r_den >> 1);
            div_req.divisor  = r_den;
        end else if (r_state == S_MUL) begin
            div_req.start    = 1'b1;
            div_req.dividend = W_DIV'(r_clk);
            div_req.divisor  = prod;
        end
    end

    assign in_ch.ready       = (r_state == S_IDLE);
    assign out_ch.valid      = (r_state == S_OUT);
    assign out_ch.applied    = r_applied;
    assign out_ch.prescaler  = r_have ? r_win_psc : '0;
    assign out_ch.reload     = r_have ? r_win_arr : '0;
    assign out_ch.freq_error = r_have ? r_best_err[W_DATA-1:0] : r_clk - r_tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_clk <= i_clock_hz;
                        r_tgt <= (in_ch.req_hz > i_clock_hz) ? i_clock_hz
                                                             : in_ch.req_hz;
                        r_psc <= (W_CNT+1)'(1);
                        r_den <= W_DIV'((in_ch.req_hz > i_clock_hz) ? i_clock_hz
                                                                   : in_ch.req_hz);
                        r_have    <= 1'b0;
                        r_applied <= (in_ch.req_hz != '0);
                        if (in_ch.req_hz == '0 || i_clock_hz == '0) begin
                            r_clk   <= '0;
                            r_tgt   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (div_req.start) r_state <= S_DIV1;
                    else               r_state <= S_OUT;
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        r_ideal <= div_rsp.quotient;
                        r_state <= S_ARR;
                    end
                end
                S_ARR: begin
                    if (r_ideal > W_DIV'({1'b0, COUNT_MAX}) + W_DIV'(1)) begin
                        r_psc   <= r_psc + (W_CNT+1)'(1);
                        r_den   <= r_den + W_DIV'(r_tgt);
                        r_state <= S_CHECK;
                    end else begin
                        r_arr   <= (r_ideal == '0) ? '0 : r_ideal[W_CNT:0] - (W_CNT+1)'(1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_DIV2;
                S_DIV2: if (div_rsp.done) r_state <= S_EVAL;
                S_EVAL: begin
                    r_psc   <= r_psc + (W_CNT+1)'(1);
                    r_den   <= r_den + W_DIV'(r_tgt);
                    r_state <= S_CHECK;
                    if (win) begin
                        r_have     <= 1'b1;
                        r_best_err <= err;
                        r_win_psc  <= r_psc[W_CNT-1:0] - W_CNT'(1);
                        r_win_arr  <= r_arr[W_CNT-1:0];
                        if (err == '0) r_state <= S_OUT;
                    end
                end
                S_OUT: if (out_ch.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
